### hdl/fral_pkg.sv
// Shared types and constants for the force resistor linearizer.
// Holds the piecewise-linear fit table and the millinewton scaling.
// No dependencies.
package fral_pkg;

  localparam int V_W      = 13;
  localparam int R_W      = 16;
  localparam int NUM_W    = 32;
  localparam int FORCE_W  = 18;
  localparam int REF_MV   = 5000;

  localparam int DIV_BITS_PER_STAGE = 2;
  localparam int DIV_STAGES         = R_W / DIV_BITS_PER_STAGE;
  localparam int FORCE_STAGES       = 6;

  localparam int SEG_N     = 10;
  localparam int SEG_IDX_W = 4;
  localparam int SLOPE_W   = 22;
  localparam int ICPT_W    = 31;
  localparam int PROD_W    = SLOPE_W + R_W;

  localparam int MN_NUM      = 981;
  localparam int MN_DIV      = 100;
  localparam int MN_FRAC     = 16;
  localparam int MN_Y_W      = ICPT_W + 10;
  localparam int MN_T_W      = MN_Y_W - MN_FRAC;
  localparam int RECIP_SHIFT = 32;
  localparam int RECIP_W     = 26;
  localparam logic [RECIP_W-1:0] RECIP100 = RECIP_W'((64'd1 << RECIP_SHIFT) / MN_DIV);
  localparam int MN_Q_W      = MN_T_W + RECIP_W - RECIP_SHIFT;

  localparam logic [R_W-1:0] SEG_ABOVE [0:SEG_N-1] = '{
    16'd30000, 16'd10000, 16'd6000, 16'd3300, 16'd2000,
    16'd1100, 16'd750, 16'd450, 16'd300, 16'd0
  };

  localparam logic [SLOPE_W-1:0] SEG_SLOPE [0:SEG_N-1] = '{
    22'd7, 22'd98, 22'd819, 22'd3401, 22'd13107,
    22'd36411, 22'd187243, 22'd436909, 22'd1310720, 22'd2808683
  };

  localparam logic [ICPT_W-1:0] SEG_ICPT [0:SEG_N-1] = '{
    31'd1507328, 31'd4259840, 31'd11468800, 31'd26942577, 31'd58982400,
    31'd105585770, 31'd271506276, 31'd458752000, 31'd851968000, 31'd1301357527
  };

  typedef struct packed {
    logic [V_W-1:0] v;
    logic           open_ckt;
  } fral_meta_t;

endpackage

### hdl/fral_div.sv
// Pipelined restoring divider giving a saturated 16-bit resistance quotient.
// Retires two quotient bits per stage; depends on fral_pkg.
module fral_div
  import fral_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_vld,
  input  logic [NUM_W-1:0] num,
  input  logic [V_W-1:0]   den,
  input  fral_meta_t       in_meta,
  output logic             out_vld,
  output logic [R_W-1:0]   quot,
  output fral_meta_t       out_meta
);

  logic             vld_r  [0:DIV_STAGES-1];
  logic [NUM_W-1:0] rem_r  [0:DIV_STAGES-1];
  logic [V_W-1:0]   den_r  [0:DIV_STAGES-1];
  logic [R_W-1:0]   quo_r  [0:DIV_STAGES-1];
  logic             ovf_r  [0:DIV_STAGES-1];
  fral_meta_t       meta_r [0:DIV_STAGES-1];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic             vld_in;
    logic [NUM_W-1:0] rem_in;
    logic [V_W-1:0]   den_in;
    logic [R_W-1:0]   quo_in;
    logic             ovf_in;
    fral_meta_t       meta_in;
    logic [NUM_W-1:0] rem_w;
    logic [NUM_W-1:0] sub_w;
    logic [R_W-1:0]   quo_w;

    if (k == 0) begin : g_first
      assign vld_in  = in_vld;
      assign rem_in  = num;
      assign den_in  = den;
      assign quo_in  = '0;
      assign ovf_in  = num >= (NUM_W'(den) << R_W);
      assign meta_in = in_meta;
    end else begin : g_next
      assign vld_in  = vld_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign den_in  = den_r[k-1];
      assign quo_in  = quo_r[k-1];
      assign ovf_in  = ovf_r[k-1];
      assign meta_in = meta_r[k-1];
    end

    always_comb begin
      rem_w = rem_in;
      quo_w = quo_in;
      sub_w = '0;
      for (int j = 0; j < DIV_BITS_PER_STAGE; j++) begin
        sub_w = NUM_W'(den_in) << (R_W - 1 - k * DIV_BITS_PER_STAGE - j);
        if (rem_w >= sub_w) begin
          rem_w = rem_w - sub_w;
          quo_w[R_W - 1 - k * DIV_BITS_PER_STAGE - j] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_in;
      end
      rem_r[k]  <= rem_w;
      den_r[k]  <= den_in;
      quo_r[k]  <= quo_w;
      ovf_r[k]  <= ovf_in;
      meta_r[k] <= meta_in;
    end
  end

  assign out_vld  = vld_r[DIV_STAGES-1];
  assign quot     = ovf_r[DIV_STAGES-1] ? '1 : quo_r[DIV_STAGES-1];
  assign out_meta = meta_r[DIV_STAGES-1];

endmodule

### hdl/fral_force.sv
// Force pipeline: segment lookup, fit evaluation and millinewton scaling.
// Six register stages; depends on fral_pkg for the fit table.
module fral_force
  import fral_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_vld,
  input  logic [R_W-1:0]     res,
  input  fral_meta_t         in_meta,
  output logic               out_vld,
  output logic [R_W-1:0]     out_res,
  output fral_meta_t         out_meta,
  output logic [FORCE_W-1:0] force_mn
);

  logic [FORCE_STAGES-1:0] vld;
  fral_meta_t              meta [0:FORCE_STAGES-1];
  logic [R_W-1:0]          rr   [0:FORCE_STAGES-1];

  logic [SEG_IDX_W-1:0] seg;
  logic [SLOPE_W-1:0]   a1;
  logic [ICPT_W-1:0]    b1;
  logic [PROD_W-1:0]    prod2;
  logic [ICPT_W-1:0]    b2;
  logic [ICPT_W-1:0]    g3;
  logic [MN_T_W-1:0]    t4;
  logic [MN_Y_W-1:0]    y_w;
  logic [MN_T_W+RECIP_W-1:0] p5;
  logic [MN_T_W-1:0]    t5;
  logic [MN_Q_W-1:0]    q0_w;
  logic [MN_T_W-1:0]    rem_w;
  logic [MN_Q_W-1:0]    q_w;
  logic [FORCE_W-1:0]   force_w;

  always_comb begin
    seg = SEG_IDX_W'(SEG_N - 1);
    for (int i = SEG_N - 2; i >= 0; i--) begin
      if (res > SEG_ABOVE[i]) begin
        seg = SEG_IDX_W'(i);
      end
    end
  end

  assign y_w   = MN_Y_W'(g3) * MN_Y_W'(MN_NUM);
  assign q0_w  = p5[MN_T_W+RECIP_W-1:RECIP_SHIFT];
  assign rem_w = t5 - MN_T_W'(MN_T_W'(q0_w) * MN_T_W'(MN_DIV));
  assign q_w   = (rem_w >= MN_T_W'(MN_DIV)) ? q0_w + 1'b1 : q0_w;
  assign force_w = (q_w > MN_Q_W'({FORCE_W{1'b1}})) ? '1 : q_w[FORCE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[FORCE_STAGES-2:0], in_vld};
    end
    meta[0] <= in_meta;
    rr[0]   <= res;
    for (int s = 1; s < FORCE_STAGES; s++) begin
      meta[s] <= meta[s-1];
      rr[s]   <= rr[s-1];
    end
    a1    <= SEG_SLOPE[seg];
    b1    <= SEG_ICPT[seg];
    prod2 <= PROD_W'(a1) * PROD_W'(rr[0]);
    b2    <= b1;
    g3    <= (prod2 >= PROD_W'(b2)) ? '0 : ICPT_W'(PROD_W'(b2) - prod2);
    t4    <= y_w[MN_Y_W-1:MN_FRAC];
    p5    <= (MN_T_W+RECIP_W)'(t4) * (MN_T_W+RECIP_W)'(RECIP100);
    t5    <= t4;
    force_mn <= force_w;
  end

  assign out_vld  = vld[FORCE_STAGES-1];
  assign out_meta = meta[FORCE_STAGES-1];
  assign out_res  = rr[FORCE_STAGES-1];

endmodule

### hdl/force_resistor_adc_to_force_unit.sv
// Top level of the force resistor linearizer: sample scaling, divider
// numerator, then the fral_div and fral_force pipelines; uses fral_pkg.
//
//   channel   signals                                  direction
//   request   start, busy, adc_code                    in (busy out)
//   config    cfg_valid, cfg_ready, cfg_index, cfg_data in (cfg_ready out)
//   result    done, voltage_mv, resistance_ohm,        out
//             open_circuit, force_mn
//
// A request is taken every cycle; busy stays low.
// Each result passes four front stages, eight divider stages of two
// quotient bits each and six force stages.
// The result strobe done lasts one cycle; the pipeline never stalls.
// Reset clears all valid bits and loads supply 5000 mV, pull-down 1500 ohm.
module force_resistor_adc_to_force_unit
  import fral_pkg::*;
#(
  parameter int ADC_BITS = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [ADC_BITS-1:0] adc_code,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  output logic                done,
  output logic [V_W-1:0]      voltage_mv,
  output logic [R_W-1:0]      resistance_ohm,
  output logic                open_circuit,
  output logic [FORCE_W-1:0]  force_mn
);

  localparam logic [1:0] REG_SUPPLY   = 2'd0;
  localparam logic [1:0] REG_PULLDOWN = 2'd1;

  localparam int X_W     = ADC_BITS + V_W;
  localparam int M_W     = V_W + 1;
  localparam int P_W     = X_W + M_W;
  localparam logic [X_W-1:0] FULL = X_W'((64'd1 << ADC_BITS) - 64'd1);
  localparam logic [M_W-1:0] RECIP_V = M_W'((64'd1 << X_W) / ((64'd1 << ADC_BITS) - 64'd1));
  localparam int LATENCY = 4 + DIV_STAGES + FORCE_STAGES;

  logic [15:0] supply_mv;
  logic [15:0] pulldown_ohm;

  logic             vld1, vld2, vld3, vld4;
  logic [X_W-1:0]   x1, x2;
  logic [P_W-1:0]   p2;
  logic [V_W-1:0]   v3, v4;
  logic [NUM_W-1:0] num4;
  logic             open4;

  logic [V_W-1:0]   q0_w;
  logic [X_W-1:0]   rem_w;

  logic             div_vld;
  logic [R_W-1:0]   div_quot;
  fral_meta_t       div_meta;
  fral_meta_t       meta4;
  logic [R_W-1:0]   res_w;
  fral_meta_t       out_meta;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      supply_mv    <= 16'd5000;
      pulldown_ohm <= 16'd1500;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SUPPLY:   supply_mv    <= cfg_data;
        REG_PULLDOWN: pulldown_ohm <= cfg_data;
        default: ;
      endcase
    end
  end

  assign q0_w  = p2[X_W+V_W-1:X_W];
  assign rem_w = x2 - (X_W'(q0_w) << ADC_BITS) + X_W'(q0_w);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
      vld4 <= 1'b0;
    end else begin
      vld1 <= start && !busy;
      vld2 <= vld1;
      vld3 <= vld2;
      vld4 <= vld3;
    end
    x1    <= X_W'(adc_code) * X_W'(REF_MV);
    p2    <= P_W'(x1) * P_W'(RECIP_V);
    x2    <= x1;
    v3    <= (rem_w >= FULL) ? q0_w + 1'b1 : q0_w;
    v4    <= v3;
    open4 <= (v3 == '0);
    num4  <= (supply_mv <= 16'(v3)) ? '0
           : NUM_W'(pulldown_ohm) * NUM_W'(supply_mv - 16'(v3));
  end

  assign meta4.v        = v4;
  assign meta4.open_ckt = open4;

  fral_div u_div (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (vld4),
    .num      (num4),
    .den      (v4),
    .in_meta  (meta4),
    .out_vld  (div_vld),
    .quot     (div_quot),
    .out_meta (div_meta)
  );

  assign res_w = div_meta.open_ckt ? '1 : div_quot;

  fral_force u_force (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (div_vld),
    .res      (res_w),
    .in_meta  (div_meta),
    .out_vld  (done),
    .out_res  (resistance_ohm),
    .out_meta (out_meta),
    .force_mn (force_mn)
  );

  assign voltage_mv   = out_meta.v;
  assign open_circuit = out_meta.open_ckt;

`ifndef ASSERT_OFF
  a_open_flag: assert property (@(posedge clk) disable iff (rst)
    done |-> (open_circuit == (voltage_mv == '0)))
    else $error("open flag disagrees with zero voltage");

  a_open_res: assert property (@(posedge clk) disable iff (rst)
    done && open_circuit |-> resistance_ohm == '1)
    else $error("open circuit without full-scale resistance");

  a_volt_range: assert property (@(posedge clk) disable iff (rst)
    done |-> voltage_mv <= V_W'(REF_MV))
    else $error("voltage above reference");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LATENCY done)
    else $error("result missing after pipeline latency");
`endif

endmodule
